[sv/ccdwb_pkg.sv]
package ccdwb_pkg;

  // Field widths fixed by the pixel format and the register map.
  localparam int unsigned PixW     = 16;
  localparam int unsigned GainW    = 24;
  localparam int unsigned GainFrac = 16;
  localparam int unsigned ProdW    = PixW + GainW;
  localparam int unsigned BinW     = 3;
  localparam int unsigned RowW     = 12;
  localparam int unsigned PosW     = 16;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [PixW-1:0] PixMax = 16'hffff;
  localparam logic [BinW-1:0] MaxBin = 3'd6;

  // Reciprocals for the bin index division: floor(d / 3) and floor(d / 5)
  // are exact for every column distance below 16384.
  localparam int unsigned     RecipW      = 14;
  localparam logic [13:0]     Recip3      = 14'd10923;
  localparam int unsigned     Recip3Shift = 15;
  localparam logic [13:0]     Recip5      = 14'd3277;
  localparam int unsigned     Recip5Shift = 14;

  typedef enum logic [2:0] {
    RegSensorWidth,
    RegWindowX,
    RegWindowY,
    RegWindowWidth,
    RegWindowHeight,
    RegBinX,
    RegBinY,
    RegExposureGain
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] sensor_width;
    logic [11:0] window_x;
    logic [11:0] window_y;
    logic [12:0] window_width;
    logic [12:0] window_height;
    logic [2:0]  bin_x;
    logic [2:0]  bin_y;
    logic [23:0] exposure_gain;
  } cfg_t;

  localparam cfg_t CfgRst = '{
    sensor_width:  13'd4096,
    window_x:      12'd0,
    window_y:      12'd0,
    window_width:  13'd4096,
    window_height: 13'd4096,
    bin_x:         3'd1,
    bin_y:         3'd1,
    exposure_gain: 24'd65536
  };

  // Decisions taken for one pixel at acceptance, consumed by the summing stage.
  typedef struct packed {
    logic acc;       // pixel lies inside the window
    logic done;      // pixel completes a bin on its row
    logic use_line;  // add the partial sum of earlier rows
    logic emit;      // bin is complete on its last row
    logic last;      // final bin of the window
    logic clr_pre;   // frame start clears the running sum first
    logic clr_post;  // row end clears the running sum afterwards
  } item_ctrl_t;

  function automatic logic [BinW-1:0] clamp_bin(logic [BinW-1:0] b);
    if (b == '0) begin
      return BinW'(1);
    end else if (b > MaxBin) begin
      return MaxBin;
    end
    return b;
  endfunction

  function automatic logic [PixW-1:0] sat_add(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [PixW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PixW] ? PixMax : s[PixW-1:0];
  endfunction

endpackage

[sv/ccdwb_cfg_regs.sv]
module ccdwb_cfg_regs import ccdwb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[RegAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSensorWidth:  cfg_q.sensor_width  <= pwdata[12:0];
        RegWindowX:      cfg_q.window_x      <= pwdata[11:0];
        RegWindowY:      cfg_q.window_y      <= pwdata[11:0];
        RegWindowWidth:  cfg_q.window_width  <= pwdata[12:0];
        RegWindowHeight: cfg_q.window_height <= pwdata[12:0];
        RegBinX:         cfg_q.bin_x         <= pwdata[2:0];
        RegBinY:         cfg_q.bin_y         <= pwdata[2:0];
        RegExposureGain: cfg_q.exposure_gain <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSensorWidth:  prdata = DataW'(cfg_q.sensor_width);
      RegWindowX:      prdata = DataW'(cfg_q.window_x);
      RegWindowY:      prdata = DataW'(cfg_q.window_y);
      RegWindowWidth:  prdata = DataW'(cfg_q.window_width);
      RegWindowHeight: prdata = DataW'(cfg_q.window_height);
      RegBinX:         prdata = DataW'(cfg_q.bin_x);
      RegBinY:         prdata = DataW'(cfg_q.bin_y);
      RegExposureGain: prdata = DataW'(cfg_q.exposure_gain);
    endcase
  end

endmodule

[sv/ccdwb_ctrl.sv]
module ccdwb_ctrl import ccdwb_pkg::*; #(
  parameter  int unsigned MaxLineWidth = 4096,
  localparam int unsigned ColW         = $clog2(MaxLineWidth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            frame_start_i,
  input  cfg_t            cfg_i,
  output item_ctrl_t      ctrl_o,
  output logic [ColW-1:0] idx_o
);

  localparam int unsigned MulW = ColW + Recip3Shift;

  logic [ColW-1:0] col_q, col_d, col_s, col;
  logic [RowW-1:0] row_q, row_d, row_s;
  logic [BinW-1:0] cib_q, cib_d, cib_s;
  logic [BinW-1:0] rib_q, rib_d, rib_s;
  logic [BinW-1:0] bx, by;
  logic [BinW:0]   cib_inc, rib_inc;
  logic [ColW:0]   sw;
  logic [PosW-1:0] col_x, row_x, x_end, y_end;
  logic            row_in, col_in, in_win, row_end, done, emit;
  logic [ColW-1:0] col_off, num;
  logic [RecipW-1:0] recip;
  logic [MulW-1:0] prod;
  logic [ColW-1:0] quot3, quot5;

  assign bx = clamp_bin(cfg_i.bin_x);
  assign by = clamp_bin(cfg_i.bin_y);

  always_comb begin
    if (cfg_i.sensor_width == '0) begin
      sw = (ColW+1)'(1);
    end else if (32'(cfg_i.sensor_width) > 32'(MaxLineWidth)) begin
      sw = (ColW+1)'(MaxLineWidth);
    end else begin
      sw = (ColW+1)'(cfg_i.sensor_width);
    end
  end

  // A frame start puts the raster position back to the origin first.
  assign col_s = frame_start_i ? '0 : col_q;
  assign row_s = frame_start_i ? '0 : row_q;
  assign cib_s = frame_start_i ? '0 : cib_q;
  assign rib_s = frame_start_i ? '0 : rib_q;
  assign col   = ({1'b0, col_s} >= sw) ? '0 : col_s;

  assign col_x  = PosW'(col);
  assign row_x  = PosW'(row_s);
  assign x_end  = PosW'(cfg_i.window_x) + PosW'(cfg_i.window_width);
  assign y_end  = PosW'(cfg_i.window_y) + PosW'(cfg_i.window_height);
  assign row_in = (row_x >= PosW'(cfg_i.window_y)) && (row_x < y_end);
  assign col_in = (col_x >= PosW'(cfg_i.window_x)) && (col_x < x_end);
  assign in_win = row_in && col_in;

  assign cib_inc = {1'b0, cib_s} + (BinW+1)'(1);
  assign rib_inc = {1'b0, rib_s} + (BinW+1)'(1);
  assign done    = in_win && (cib_inc >= {1'b0, bx});
  assign emit    = done && (rib_inc >= {1'b0, by});
  assign row_end = ({1'b0, col} + (ColW+1)'(1)) >= sw;

  always_comb begin
    ctrl_o.acc      = in_win;
    ctrl_o.done     = done;
    ctrl_o.use_line = (rib_s != '0);
    ctrl_o.emit     = emit;
    ctrl_o.last     = ((col_x + PosW'(bx)) >= x_end) && ((row_x + PosW'(by)) >= y_end);
    ctrl_o.clr_pre  = frame_start_i;
    ctrl_o.clr_post = row_end;
  end

  // Bin column index: the window offset divided by the horizontal factor.
  assign col_off = ColW'(col_x - PosW'(cfg_i.window_x));
  assign num     = (bx == 3'd6) ? (col_off >> 1) : col_off;
  assign recip   = (bx == 3'd5) ? Recip5 : Recip3;
  assign prod    = MulW'(num) * MulW'(recip);
  assign quot3   = ColW'(prod >> Recip3Shift);
  assign quot5   = ColW'(prod >> Recip5Shift);

  always_comb begin
    unique case (bx)
      3'd2:    idx_o = col_off >> 1;
      3'd3:    idx_o = quot3;
      3'd4:    idx_o = col_off >> 2;
      3'd5:    idx_o = quot5;
      3'd6:    idx_o = quot3;
      default: idx_o = col_off;
    endcase
  end

  always_comb begin
    col_d = row_end ? '0 : (col + ColW'(1));
    row_d = row_end ? (row_s + RowW'(1)) : row_s;
    if (row_end) begin
      cib_d = '0;
    end else if (in_win) begin
      cib_d = done ? '0 : cib_inc[BinW-1:0];
    end else begin
      cib_d = cib_s;
    end
    if (row_end && row_in) begin
      rib_d = (rib_inc >= {1'b0, by}) ? '0 : rib_inc[BinW-1:0];
    end else begin
      rib_d = rib_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cib_q <= '0;
      rib_q <= '0;
    end else if (in_fire_i) begin
      col_q <= col_d;
      row_q <= row_d;
      cib_q <= cib_d;
      rib_q <= rib_d;
    end
  end

endmodule

[sv/ccdwb_line_ram.sv]
module ccdwb_line_ram import ccdwb_pkg::*; #(
  parameter  int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [PixW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [PixW-1:0]  rdata_o
);

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

[sv/ccdwb_accum.sv]
module ccdwb_accum import ccdwb_pkg::*; #(
  parameter int unsigned IdxW = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [PixW-1:0]  pixel_value_i,
  input  logic [GainW-1:0] gain_i,
  input  item_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [PixW-1:0]  line_rdata_i,
  output logic             adv_o,
  output logic             line_we_o,
  output logic [IdxW-1:0]  line_waddr_o,
  output logic [PixW-1:0]  line_wdata_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PixW-1:0]  binned_value_o,
  output logic             frame_last_o
);

  logic             s1_valid_q;
  item_ctrl_t       s1_ctrl_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [ProdW-1:0] s1_prod_q;
  logic             fwd_q;
  logic [PixW-1:0]  fwd_data_q;
  logic [PixW-1:0]  hsum_q, hsum_d;
  logic             out_valid_q;
  logic [PixW-1:0]  out_value_q;
  logic             out_last_q;

  logic             out_free, s1_fire, wr_en, load;
  logic [PixW-1:0]  scaled, base, sum, line, bin_value;

  assign scaled = (s1_prod_q[ProdW-1:GainFrac+PixW] != '0) ? PixMax
                                                           : s1_prod_q[GainFrac +: PixW];
  assign base      = s1_ctrl_q.clr_pre ? '0 : hsum_q;
  assign sum       = s1_ctrl_q.acc ? sat_add(base, scaled) : base;
  // The line entry may be written by the previous pixel in the very cycle it was read.
  assign line      = fwd_q ? fwd_data_q : line_rdata_i;
  assign bin_value = s1_ctrl_q.use_line ? sat_add(sum, line) : sum;
  assign hsum_d    = (s1_ctrl_q.done || s1_ctrl_q.clr_post) ? '0 : sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign adv_o    = !s1_valid_q || !s1_ctrl_q.emit || out_free;
  assign s1_fire  = s1_valid_q && adv_o;
  assign wr_en    = s1_fire && s1_ctrl_q.done && !s1_ctrl_q.emit;
  assign load     = s1_fire && s1_ctrl_q.emit;

  assign line_we_o    = wr_en;
  assign line_waddr_o = s1_idx_q;
  assign line_wdata_o = bin_value;

  assign out_valid_o    = out_valid_q;
  assign binned_value_o = out_value_q;
  assign frame_last_o   = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      hsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        s1_valid_q <= in_fire_i;
      end
      if (in_fire_i) begin
        fwd_q <= wr_en && (s1_idx_q == idx_i);
      end
      if (s1_fire) begin
        hsum_q <= hsum_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_ctrl_q  <= ctrl_i;
      s1_idx_q   <= idx_i;
      s1_prod_q  <= ProdW'(pixel_value_i) * ProdW'(gain_i);
      fwd_data_q <= bin_value;
    end
    if (load) begin
      out_value_q <= bin_value;
      out_last_q  <= s1_ctrl_q.last;
    end
  end

  a_hold_only_on_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv_o |-> s1_ctrl_q.emit && out_valid_q && out_stall_i)
    else $error("summing stage held without a waiting result");

  a_emit_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ctrl_q.emit |-> s1_ctrl_q.done && s1_ctrl_q.acc)
    else $error("result emitted for a pixel that completes no bin");

  a_row_end_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_ctrl_q.clr_post |=> hsum_q == '0)
    else $error("running sum survived the end of a row");

endmodule

[sv/ccd_window_pixel_binning_top.sv]
// A pixel completing a bin is registered on acceptance and its result is offered from the
//   output register once that is free. Throughput: one pixel transaction per clock unless
//   a result waits at a stalled output; the acceptance and summing stages, the line
//   store's separate read and write ports and one gain multiplier all work at that rate.
// Reset (rst_ni, asynchronous, active low) restores the register defaults, the raster position
//   and the empty pipeline; the line store is not cleared and needs no clearing pass.
module ccd_window_pixel_binning_top import ccdwb_pkg::*; #(
  parameter int unsigned MaxLineWidth = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     pixel_value_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     binned_value_o,
  output logic                frame_last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(MaxLineWidth);

  // The datapath is two registered stages. At acceptance the raster counters decide
  // whether the pixel lies in the window, whether it closes a bin, and which line store
  // entry holds the partial sum of its bin column; the entry is read and the pixel is
  // multiplied by the gain in the same cycle. The summing stage then saturates the
  // product, adds it to the running row sum, folds in the line entry on later rows and
  // either writes the partial sum back or hands the finished bin to the output register.
  // A new pixel transaction is taken whenever the summing stage can move on, which is
  // always unless it holds a finished bin while the output register is still stalled.

  cfg_t            cfg;
  item_ctrl_t      item_ctrl;
  logic [IdxW-1:0] item_idx;
  logic            adv;
  logic            in_fire;
  logic            line_we;
  logic [IdxW-1:0] line_waddr;
  logic [PixW-1:0] line_wdata;
  logic [PixW-1:0] line_rdata;

  assign in_stall_o = !adv;
  assign in_fire    = in_valid_i && adv;

  ccdwb_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccdwb_ctrl #(
    .MaxLineWidth (MaxLineWidth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .ctrl_o        (item_ctrl),
    .idx_o         (item_idx)
  );

  // Partial bin sums carried from one row to the next, one entry per bin column.
  ccdwb_line_ram #(
    .Depth (MaxLineWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (in_fire),
    .raddr_i (item_idx),
    .rdata_o (line_rdata)
  );

  ccdwb_accum #(
    .IdxW (IdxW)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .pixel_value_i  (pixel_value_i),
    .gain_i         (cfg.exposure_gain),
    .ctrl_i         (item_ctrl),
    .idx_i          (item_idx),
    .line_rdata_i   (line_rdata),
    .adv_o          (adv),
    .line_we_o      (line_we),
    .line_waddr_o   (line_waddr),
    .line_wdata_o   (line_wdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .binned_value_o (binned_value_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

[tb/ccd_window_pixel_binning_top_test.sv]
module ccd_window_pixel_binning_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccdwb_pkg::*;

  // The random part stops once about this many pixel transactions have been sent.
  localparam int unsigned RandomItems = 1750;
  // Depth of the line store, matching the default line width of the block.
  localparam int unsigned LineDepth = 4096;
  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int unsigned HoldCycles = 300;

  // ---------------------------------------------------------------------------
  // Scoreboard. It mirrors the register file and the binning state, predicts the
  // binned pixel (if any) that each accepted pixel transaction produces, and holds
  // the predictions in order until the matching result transaction arrives.
  // ---------------------------------------------------------------------------
  class binning_scoreboard;
    typedef struct packed {
      logic [PixW-1:0] value;
      logic            last;
    } binned_pixel_t;

    cfg_t            cfg;
    logic [11:0]     col_pos;
    logic [RowW-1:0] row_pos;
    logic [BinW-1:0] bin_col;
    logic [BinW-1:0] bin_row;
    logic [PixW-1:0] row_partial;
    logic [PixW-1:0] column_partials [LineDepth];
    binned_pixel_t   expected_bins [$];
    int unsigned     mismatches;

    function new();
      cfg         = CfgRst;
      col_pos     = '0;
      row_pos     = '0;
      bin_col     = '0;
      bin_row     = '0;
      row_partial = '0;
      mismatches  = 0;
      foreach (column_partials[i]) column_partials[i] = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] data);
      case (idx)
        RegSensorWidth:  cfg.sensor_width  = data[12:0];
        RegWindowX:      cfg.window_x      = data[11:0];
        RegWindowY:      cfg.window_y      = data[11:0];
        RegWindowWidth:  cfg.window_width  = data[12:0];
        RegWindowHeight: cfg.window_height = data[12:0];
        RegBinX:         cfg.bin_x         = data[2:0];
        RegBinY:         cfg.bin_y         = data[2:0];
        RegExposureGain: cfg.exposure_gain = data[23:0];
        default: ;
      endcase
    endfunction

    // A bin factor of zero behaves as one, anything above six as six.
    function int unsigned bin_span(logic [BinW-1:0] b);
      if (b == 0) return 1;
      if (b > 6) return 6;
      return 32'(b);
    endfunction

    function int unsigned sat16(int unsigned a, int unsigned b);
      return (a + b > 'hffff) ? 'hffff : a + b;
    endfunction

    // Advances the raster position by one pixel and queues the binned pixel it
    // completes.
    function void note_pixel(logic [PixW-1:0] pix, logic start);
      int unsigned   bx, by, width, col, row, idx, sum, scaled;
      int unsigned   wx, wy, ww, wh;
      longint unsigned prod;
      bit            in_rows, in_cols;
      binned_pixel_t bin;
      bx = bin_span(cfg.bin_x);
      by = bin_span(cfg.bin_y);
      width = 32'(cfg.sensor_width);
      if (width == 0) width = 1;
      if (width > LineDepth) width = LineDepth;
      wx = 32'(cfg.window_x);
      wy = 32'(cfg.window_y);
      ww = 32'(cfg.window_width);
      wh = 32'(cfg.window_height);
      if (start) begin
        col_pos     = '0;
        row_pos     = '0;
        bin_col     = '0;
        bin_row     = '0;
        row_partial = '0;
      end
      if (col_pos >= width) col_pos = '0;
      col = 32'(col_pos);
      row = 32'(row_pos);
      in_rows = (row >= wy) && (row < wy + wh);
      in_cols = (col >= wx) && (col < wx + ww);
      if (in_rows && in_cols) begin
        prod = (64'(pix) * 64'(cfg.exposure_gain)) >> GainFrac;
        scaled = (prod > 'hffff) ? 'hffff : 32'(prod);
        row_partial = PixW'(sat16(32'(row_partial), scaled));
        bin_col = bin_col + BinW'(1);
        if (bin_col >= bx) begin
          idx = ((col - wx) / bx) % LineDepth;
          sum = 32'(row_partial);
          if (bin_row != 0) sum = sat16(sum, 32'(column_partials[idx]));
          if (bin_row + 1 >= by) begin
            bin.value = PixW'(sum);
            bin.last  = (col + bx >= wx + ww) && (row + by >= wy + wh);
            expected_bins.push_back(bin);
          end else begin
            column_partials[idx] = PixW'(sum);
          end
          bin_col     = '0;
          row_partial = '0;
        end
      end
      if (col + 1 >= width) begin
        if (in_rows) begin
          bin_row = bin_row + BinW'(1);
          if (bin_row >= by) bin_row = '0;
        end
        bin_col     = '0;
        row_partial = '0;
        col_pos     = '0;
        row_pos     = row_pos + RowW'(1);
      end else begin
        col_pos = 12'(col + 1);
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= 50) begin
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      end
    endtask

    task check_binned(logic [PixW-1:0] value, logic last);
      binned_pixel_t want;
      if (expected_bins.size() == 0) begin
        report("unexpected binned pixel", 32'(value), 0);
        return;
      end
      want = expected_bins.pop_front();
      if (value !== want.value) report("binned_value", 32'(value), 32'(want.value));
      if (last !== want.last) report("frame_last", 32'(last), 32'(want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_value_i = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [PixW-1:0]     binned_value_o;
  logic                frame_last_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [RegAddrW-1:0] paddr         = '0;
  logic [DataW-1:0]    pwdata        = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  binning_scoreboard sb = new();

  // Idle rates, in percent, for the pixel sender and the result receiver. The
  // stimulus changes them as the run moves through its idling regimes.
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 62;
  // A request for one long receiver hold-off, and the cycles it has still to run.
  int unsigned hold_pending = 0;
  int unsigned hold_left = 0;
  // Pixel transactions accepted by the block, used to decide when to stop and which idling regime applies.
  int unsigned sent_count = 0;

  ccd_window_pixel_binning_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .binned_value_o (binned_value_o),
    .frame_last_o   (frame_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result receiver. Outside a hold-off it stalls at random at the current rate.
  // When a hold-off is requested it keeps the stall raised until hold_left runs out,
  // so that the pipeline fills up and the block has to stall its own input.
  always @(posedge clk_i) begin
    if (hold_pending != 0) begin
      hold_left = HoldCycles;
      hold_pending = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor. Outputs are read straight after the edge, so they hold the
  // values that the edge itself sampled; a transaction completes when valid is
  // high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_binned(binned_value_o, frame_last_o);
    end
  end

  // One register write: a setup phase, then an access phase held until pready.
  // The select is left raised so that writes can follow back to back; the caller
  // releases the bus once the last write has gone.
  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, data);
  endtask

  // Writes the whole register file. Only ever called with the block idle.
  task automatic configure(int unsigned sensor_width, int unsigned window_x,
                           int unsigned window_y, int unsigned window_width,
                           int unsigned window_height, int unsigned bin_x,
                           int unsigned bin_y, int unsigned gain);
    write_reg(RegSensorWidth, sensor_width);
    write_reg(RegWindowX, window_x);
    write_reg(RegWindowY, window_y);
    write_reg(RegWindowWidth, window_width);
    write_reg(RegWindowHeight, window_height);
    write_reg(RegBinX, bin_x);
    write_reg(RegBinY, bin_y);
    write_reg(RegExposureGain, gain);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one pixel transaction, after a random number of idle cycles, and holds
  // it steady until the block accepts it. Valid stays high after acceptance; the
  // next call either lowers it while it idles or presents the next pixel.
  task automatic send_pixel(logic [PixW-1:0] pix, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    frame_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(pix, start);
    sent_count++;
  endtask

  // Sends a raster of the given number of full sensor rows, with a frame start on
  // the first pixel. On request a second, stray frame start is thrown in part way.
  task automatic send_frame(int unsigned rows, bit with_restart);
    int unsigned     len;
    int              total, restart_at, n;
    logic [PixW-1:0] pix;
    len = sb.cfg.sensor_width;
    if (len == 0) len = 1;
    if (len > LineDepth) len = LineDepth;
    total = rows * len;
    restart_at = (with_restart && total > 1) ? $urandom_range(1, total - 1) : -1;
    for (n = 0; n < total; n++) begin
      case ($urandom_range(7))
        0: pix = '1;
        1: pix = '0;
        default: pix = PixW'($urandom);
      endcase
      send_pixel(pix, (n == 0) || (n == restart_at));
    end
  endtask

  // Stops offering pixels and waits until every predicted binned pixel has come
  // out and pixels that produce nothing have also left the pipeline, before the
  // registers are touched.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sw, swe, wx, wy, ww, wh, bx, by, bxe, bye, gain, rows, frames, k;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First regime: the sender idles now and then, the receiver often.
    send_idle_pct = 13;
    recv_idle_pct = 62;

    // Registers at their reset values: full window, no binning and unity gain, so
    // each pixel comes straight through as its own binned pixel.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h0001, 1'b0);
    drain();

    // Largest gain: products saturate, a single count gives the fraction's top.
    configure(3, 0, 0, 3, 1, 1, 1, 24'hffffff);
    send_pixel(16'hffff, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h0100, 1'b0);
    drain();

    // Zero gain wipes every pixel out.
    configure(1, 0, 0, 1, 1, 1, 1, 0);
    send_pixel(16'hffff, 1'b1);
    drain();

    // Bin factors of zero and seven stand for one and six.
    configure(1, 0, 0, 1, 6, 0, 7, 24'h010000);
    send_frame(6, 1'b0);
    drain();

    // Window neither a multiple of the bin nor inside the sensor row: the partial
    // bin at the right edge and the spare row at the bottom are dropped.
    configure(4, 1, 0, 4, 3, 2, 2, 24'h010000);
    send_frame(3, 1'b0);
    drain();

    // A sensor width of zero means a single column.
    configure(0, 0, 0, 1, 2, 1, 2, 24'h008000);
    send_frame(2, 1'b0);
    drain();

    // A sensor width beyond the line store clips to the full store width; only
    // the start of the first row is sent.
    configure(8191, 0, 0, 4, 1, 2, 1, 24'h010000);
    for (k = 0; k < 8; k++) send_pixel(PixW'($urandom), k == 0);
    drain();

    // Back pressure: every pixel yields a result while the receiver holds off for
    // a long stretch, so the pipeline fills and the input has to stall.
    configure(8, 0, 0, 8, 8, 1, 1, 24'h010000);
    hold_pending = 1;
    send_frame(8, 1'b0);
    drain();

    // Random part. Each phase picks a fresh configuration, mostly one that yields
    // complete bins, and sends whole frames with random content; a few frames are
    // cut short or carry a stray frame start.
    sent_count = 0;
    while (sent_count < RandomItems) begin
      if (sent_count < RandomItems / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 62;
      end else if (sent_count < 2 * RandomItems / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      sw  = ($urandom_range(15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 16);
      swe = (sw == 0) ? 1 : sw;
      bx  = $urandom_range(0, 7);
      by  = $urandom_range(0, 7);
      bxe = (bx == 0) ? 1 : ((bx > 6) ? 6 : bx);
      bye = (by == 0) ? 1 : ((by > 6) ? 6 : by);
      wx  = ($urandom_range(3) == 0) ? $urandom_range(0, swe - 1) : 0;
      k   = (swe - wx) / bxe;
      if (k == 0) k = 1;
      ww  = bxe * $urandom_range(1, k);
      if ($urandom_range(3) == 0) ww += $urandom_range(0, bxe - 1);
      if ($urandom_range(7) == 0) ww = $urandom_range(0, 40);
      wy  = $urandom_range(0, 2);
      wh  = bye * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) wh += $urandom_range(0, bye - 1);
      if ($urandom_range(19) == 0) wh = 0;
      case ($urandom_range(4))
        0: gain = 24'h010000;
        1: gain = $urandom_range(0, 24'hffffff);
        2: gain = $urandom_range(0, 24'h020000);
        3: gain = $urandom_range(24'h008000, 24'h030000);
        default: gain = $urandom_range(1) ? 24'hffffff : 0;
      endcase
      configure(sw, wx, wy, ww, wh, bx, by, gain);

      frames = $urandom_range(1, 3);
      repeat (frames) begin
        rows = wy + wh + $urandom_range(0, 1);
        if (rows == 0) rows = 1;
        if ($urandom_range(7) == 0) rows = $urandom_range(1, rows);
        send_frame(rows, $urandom_range(9) == 0);
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this.
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
sv/ccdwb_pkg.sv
sv/ccdwb_cfg_regs.sv
sv/ccdwb_ctrl.sv
sv/ccdwb_line_ram.sv
sv/ccdwb_accum.sv
sv/ccd_window_pixel_binning_top.sv
tb/ccd_window_pixel_binning_top_test.sv
